// ===== src/bitfield_layout_packer_macros.svh =====
// Assertion macros shared by the packer RTL.
// Every check is sampled on the rising edge of clk and is held off while rst_n is low.
`ifndef BITFIELD_LAYOUT_PACKER_MACROS_SVH
`define BITFIELD_LAYOUT_PACKER_MACROS_SVH

// The property must hold in the same cycle that it is sampled.
`define BLP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition in one cycle implies the expression in the next cycle.
`define BLP_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== src/blp_pkg.sv =====
`timescale 1ns / 1ps

package blp_pkg;

    // Sizes in bytes and bit counts used by the placement rules.
    localparam logic [3:0] BYTE_BITS   = 4'd8;
    localparam logic [3:0] SHORT_BYTES = 4'd2;
    localparam logic [3:0] INT_BYTES   = 4'd4;
    localparam logic [3:0] MAX_BYTES   = 4'd8;
    localparam logic [6:0] USED_MAX    = 7'd127;

    // Beat widths on the two channels.
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 48;

    // Residue table: entry v holds v modulo m, for a byte-wide v.
    typedef logic [255:0][2:0] res_tbl_t;

    // Built by a wrapping counter, so no divider is involved.
    function automatic res_tbl_t build_res_tbl(input int unsigned m);
        res_tbl_t    tbl;
        int unsigned r;
        r = 0;
        for (int i = 0; i < 256; i++)
        begin
            tbl[i] = r[2:0];
            if (r == m - 1)
                r = 0;
            else
                r = r + 1;
        end
        return tbl;
    endfunction

    localparam res_tbl_t MOD3_TBL = build_res_tbl(3);
    localparam res_tbl_t MOD5_TBL = build_res_tbl(5);
    localparam res_tbl_t MOD6_TBL = build_res_tbl(6);
    localparam res_tbl_t MOD7_TBL = build_res_tbl(7);

    // Byte-wide residue for the sizes that are not a power of two.
    function automatic logic [2:0] res_lookup(input logic [7:0] v, input logic [3:0] m);
        logic [2:0] res;
        case (m)
            4'd3:    res = MOD3_TBL[v];
            4'd5:    res = MOD5_TBL[v];
            4'd6:    res = MOD6_TBL[v];
            4'd7:    res = MOD7_TBL[v];
            default: res = 3'd0;
        endcase
        return res;
    endfunction

    // A 32-bit value modulo a container size of one to eight bytes.
    // Powers of two are masks. Other sizes fold the four byte residues,
    // each weighted by 256^k modulo m, then reduce the small sum once more.
    function automatic logic [2:0] mod_small(input logic [31:0] x, input logic [3:0] m);
        logic [2:0] r0;
        logic [2:0] r1;
        logic [2:0] r2;
        logic [2:0] r3;
        logic [2:0] w1;
        logic [2:0] w2;
        logic [2:0] w3;
        logic [7:0] acc;
        logic [2:0] res;
        r0 = res_lookup(x[7:0], m);
        r1 = res_lookup(x[15:8], m);
        r2 = res_lookup(x[23:16], m);
        r3 = res_lookup(x[31:24], m);
        case (m)
            4'd6:
            begin
                w1 = 3'd4;
                w2 = 3'd4;
                w3 = 3'd4;
            end
            4'd7:
            begin
                w1 = 3'd4;
                w2 = 3'd2;
                w3 = 3'd1;
            end
            default:
            begin
                w1 = 3'd1;
                w2 = 3'd1;
                w3 = 3'd1;
            end
        endcase
        acc = {5'd0, r0} + ({5'd0, r1} * {5'd0, w1}) + ({5'd0, r2} * {5'd0, w2})
            + ({5'd0, r3} * {5'd0, w3});
        case (m)
            4'd1:    res = 3'd0;
            4'd2:    res = {2'd0, x[0]};
            4'd4:    res = {1'd0, x[1:0]};
            4'd8:    res = x[2:0];
            default: res = res_lookup(acc, m);
        endcase
        return res;
    endfunction

    // Declared size forced into the range of one to eight bytes.
    function automatic logic [3:0] clean_size(input logic [3:0] raw);
        logic [3:0] s;
        if (raw == 4'd0)
            s = 4'd1;
        else if (raw > MAX_BYTES)
            s = MAX_BYTES;
        else
            s = raw;
        return s;
    endfunction

endpackage

// ===== src/bitfield_layout_packer.sv =====
`timescale 1ns / 1ps
`include "bitfield_layout_packer_macros.svh"

// Bitfield layout packer.
// Input stream (s_axis_*): one beat per struct member step. tuser carries the
// mode: a break to the next container (no result) or a bitfield to place.
// Output stream (m_axis_*): one beat per placed field with the container byte
// offset, the start bit counted down from the container top and the size used.
// The block is a four-register pipeline: input register, base offset (multiply
// and add of the preceding member), group-start alignment, then the placement
// state update that loads the result register. One beat is accepted every
// cycle while s_axis_tready is high. The placement state is a single loop,
// so steps follow each other back to back. Each stage advances whenever the
// stage after it is empty or moving, so bubbles close up. When the receiver
// stalls, the pipeline fills up to four beats and then s_axis_tready falls.
// Reset empties every stage and clears the container offset, bits used,
// misalignment and last size.
module bitfield_layout_packer
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // group_start, has_prev, prev_offset[23:0], prev_size[15:0],
    // prev_count[15:0], declared_size[3:0], field_bits[6:0], zero pad
    input  logic [blp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // mode
    input  logic [0:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // byte_offset[31:0], start_bit[5:0], effective_size[3:0], zero pad
    output logic [blp_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import blp_pkg::*;

    // Input register.
    logic        s1_valid_reg;
    logic        s1_mode_reg;
    logic        s1_gstart_reg;
    logic        s1_hprev_reg;
    logic [23:0] s1_poff_reg;
    logic [15:0] s1_psize_reg;
    logic [15:0] s1_pcount_reg;
    logic [3:0]  s1_dsize_reg;
    logic [6:0]  s1_fbits_reg;

    // Base offset stage.
    logic        s2_valid_reg;
    logic        s2_mode_reg;
    logic        s2_gstart_reg;
    logic [3:0]  s2_size_reg;
    logic [6:0]  s2_fbits_reg;
    logic [31:0] s2_base_reg;

    // Group-start alignment stage.
    logic        s3_valid_reg;
    logic        s3_mode_reg;
    logic        s3_gstart_reg;
    logic [3:0]  s3_size_reg;
    logic [6:0]  s3_fbits_reg;
    logic [3:0]  s3_gsize_reg;
    logic [2:0]  s3_gmis_reg;
    logic [31:0] s3_gco_reg;

    // Placement state.
    logic [31:0] co_reg;
    logic [31:0] co_next;
    logic [6:0]  bu_reg;
    logic [6:0]  bu_next;
    logic [2:0]  mis_reg;
    logic [2:0]  mis_next;
    logic [3:0]  ls_reg;
    logic [3:0]  ls_next;

    // Result register.
    logic        out_valid_reg;
    logic [31:0] out_offset_reg;
    logic [5:0]  out_start_reg;
    logic [3:0]  out_size_reg;

    // Stage advance chain, from the output back to the input.
    logic out_adv;
    logic s3_adv;
    logic s2_adv;
    logic s1_adv;

    assign out_adv       = !out_valid_reg || m_axis_tready;
    assign s3_adv        = !s3_valid_reg || out_adv;
    assign s2_adv        = !s2_valid_reg || s3_adv;
    assign s1_adv        = !s1_valid_reg || s2_adv;
    assign s_axis_tready = s1_adv;

    // Base offset of a new group: end of the preceding member.
    logic [31:0] prod;
    logic [31:0] base;

    assign prod = {16'd0, s1_psize_reg} * {16'd0, s1_pcount_reg};
    assign base = s1_hprev_reg ? ({8'd0, s1_poff_reg} + prod) : 32'd0;

    // Group-start alignment: widen an even short, then split off the misalignment.
    logic [3:0]  gsize;
    logic [2:0]  gmis;
    logic [31:0] gco;

    assign gsize = (s2_size_reg == SHORT_BYTES && !s2_base_reg[0]) ? INT_BYTES : s2_size_reg;
    assign gmis  = mod_small(s2_base_reg, gsize);
    assign gco   = s2_base_reg - {29'd0, gmis};

    // Placement of one field against the current state.
    logic [3:0] place_size;
    logic [31:0] co1;
    logic [6:0]  bu1;
    logic [2:0]  mis1;
    logic [3:0]  ls1;
    logic [6:0]  cap;
    logic [4:0]  fill_bytes;
    logic [31:0] co_adj;
    logic [31:0] co2;
    logic [6:0]  bu2;
    logic [2:0]  mis2;
    logic [7:0]  fit_sum;
    logic [6:0]  start;
    logic [7:0]  used_sum;
    logic [2:0]  brk_mod;

    always_comb
    begin
        if (s3_gstart_reg)
        begin
            place_size = s3_gsize_reg;
            co1        = s3_gco_reg;
            bu1        = {1'b0, s3_gmis_reg, 3'd0};
            mis1       = s3_gmis_reg;
            ls1        = s3_gsize_reg;
        end
        else
        begin
            // Offset minus misalignment is even when the low bits agree.
            if (s3_size_reg == SHORT_BYTES && (co_reg[0] == mis_reg[0]))
                place_size = INT_BYTES;
            else
                place_size = s3_size_reg;
            co1  = co_reg;
            bu1  = bu_reg;
            mis1 = mis_reg;
            ls1  = ls_reg;
        end

        cap        = {place_size, 3'd0};
        fill_bytes = 5'(({1'b0, bu1} + 8'(BYTE_BITS) - 8'd1) >> 3);
        co_adj     = co1 + {27'd0, fill_bytes};
        fit_sum    = {1'b0, s3_fbits_reg} + {1'b0, bu1};

        if (place_size != ls1)
        begin
            // New container size: start past the used bytes, even-aligned.
            co2  = co_adj + {31'd0, (place_size > 4'd1) && co_adj[0]};
            bu2  = 7'd0;
            mis2 = 3'd0;
        end
        else if (fit_sum > {1'b0, cap})
        begin
            // Field does not fit: move on to the next container.
            co2  = co1 + {28'd0, place_size};
            bu2  = (cap < bu1) ? (bu1 - cap) : 7'd0;
            mis2 = 3'd0;
        end
        else
        begin
            co2  = co1;
            bu2  = bu1;
            mis2 = mis1;
        end

        start    = cap - bu2 - s3_fbits_reg;
        used_sum = {1'b0, bu2} + {1'b0, s3_fbits_reg};
        brk_mod  = mod_small(co_reg, s3_size_reg);

        // Next state: a break rounds down and steps one container.
        if (!s3_mode_reg)
        begin
            co_next  = co_reg - {29'd0, brk_mod} + {28'd0, s3_size_reg};
            bu_next  = 7'd0;
            mis_next = mis_reg;
            ls_next  = s3_size_reg;
        end
        else
        begin
            co_next  = co2;
            bu_next  = (used_sum > {1'b0, USED_MAX}) ? USED_MAX : used_sum[6:0];
            mis_next = mis2;
            ls_next  = place_size;
        end
    end

    // Pipeline control and placement state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            co_reg        <= 32'd0;
            bu_reg        <= 7'd0;
            mis_reg       <= 3'd0;
            ls_reg        <= 4'd0;
        end
        else
        begin
            if (s1_adv)
                s1_valid_reg <= s_axis_tvalid;
            if (s2_adv)
                s2_valid_reg <= s1_valid_reg;
            if (s3_adv)
                s3_valid_reg <= s2_valid_reg;
            if (out_adv)
                out_valid_reg <= s3_valid_reg && s3_mode_reg;
            if (s3_valid_reg && out_adv)
            begin
                co_reg  <= co_next;
                bu_reg  <= bu_next;
                mis_reg <= mis_next;
                ls_reg  <= ls_next;
            end
        end
    end

    // Payload registers of each stage.
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_mode_reg   <= s_axis_tuser[0];
            s1_gstart_reg <= s_axis_tdata[0];
            s1_hprev_reg  <= s_axis_tdata[1];
            s1_poff_reg   <= s_axis_tdata[25:2];
            s1_psize_reg  <= s_axis_tdata[41:26];
            s1_pcount_reg <= s_axis_tdata[57:42];
            s1_dsize_reg  <= s_axis_tdata[61:58];
            s1_fbits_reg  <= s_axis_tdata[68:62];
        end
        if (s2_adv)
        begin
            s2_mode_reg   <= s1_mode_reg;
            s2_gstart_reg <= s1_gstart_reg;
            s2_size_reg   <= clean_size(s1_dsize_reg);
            s2_fbits_reg  <= s1_fbits_reg;
            s2_base_reg   <= base;
        end
        if (s3_adv)
        begin
            s3_mode_reg   <= s2_mode_reg;
            s3_gstart_reg <= s2_gstart_reg;
            s3_size_reg   <= s2_size_reg;
            s3_fbits_reg  <= s2_fbits_reg;
            s3_gsize_reg  <= gsize;
            s3_gmis_reg   <= gmis;
            s3_gco_reg    <= gco;
        end
        if (out_adv)
        begin
            out_offset_reg <= co2;
            out_start_reg  <= start[5:0];
            out_size_reg   <= place_size;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_size_reg, out_start_reg, out_offset_reg};

    // A break step leaves no beat in the result register.
    `BLP_ASSERT_NEXT(a_break_no_beat, s3_valid_reg && out_adv && !s3_mode_reg, !out_valid_reg,
        "break step produced a result beat")

    // While the result is stalled the placement state must not move.
    `BLP_ASSERT_NEXT(a_state_held, out_valid_reg && !m_axis_tready,
        $stable(co_reg) && $stable(bu_reg),
        "placement state changed during an output stall")

    // Group-start misalignment stays inside its container.
    `BLP_ASSERT(a_gmis_range,
        !s3_valid_reg || !s3_gstart_reg || ({1'b0, s3_gmis_reg} < s3_gsize_reg),
        "group start misalignment not below container size")

    // An accepted beat always lands in the input register.
    `BLP_ASSERT_NEXT(a_accept_loads, s_axis_tvalid && s_axis_tready, s1_valid_reg,
        "accepted beat missing from input register")

endmodule
